@@ hw/rtl/qmm_pkg.sv @@
// ----------------------------------------------------------------------------
// qmm_pkg
// Widths, constants and register codes shared by the quad motor mixer files.
// ----------------------------------------------------------------------------
package qmm_pkg;

	localparam int WIDTH_W  = 15;
	localparam int OFFSET_W = 8;
	localparam int POWER_W  = 19;
	localparam int THR_W    = 8;
	localparam int GAIN_W   = 18;
	localparam int PROD_W   = WIDTH_W + GAIN_W;
	localparam int FRAC_W   = 16;
	localparam int SUM_W    = PROD_W + 4;
	localparam int DEM_W    = SUM_W - FRAC_W;
	localparam int BASE_W   = 10;
	localparam int SLEW_W   = 17;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;
	localparam int NUM_MOTORS = 4;

	// 10/pi in unsigned Q16
	localparam logic [GAIN_W-1:0] MIX_GAIN = 18'd208608;

	localparam logic [THR_W-1:0] THR_MAX   = 8'd160;
	localparam logic [THR_W-1:0] THR_MIN   = 8'd100;
	localparam logic [THR_W-1:0] THR_RESET = 8'd120;
	localparam logic signed [SLEW_W-1:0] SLEW_LIMIT = 17'sd10;
	localparam logic signed [SLEW_W-1:0] SLEW_STEP  = 17'sd5;
	localparam logic signed [POWER_W-1:0] MOTOR_RESET = 19'sd100;
	localparam logic signed [DEM_W-1:0] DEMAND_LIMIT = 21'sd160;

	typedef logic [WIDTH_W-1:0]         width_t;
	typedef logic signed [OFFSET_W-1:0] offset_t;
	typedef logic signed [POWER_W-1:0]  power_t;
	typedef logic [THR_W-1:0]           thr_t;
	typedef logic [PROD_W-1:0]          prod_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic signed [DEM_W-1:0]    demand_t;

	typedef enum logic [1:0] {
		REG_OFFSET_ONE   = 2'd0,
		REG_OFFSET_TWO   = 2'd1,
		REG_OFFSET_THREE = 2'd2,
		REG_OFFSET_FOUR  = 2'd3
	} reg_idx_t;

endpackage

@@ hw/rtl/qmm_if.sv @@
// ----------------------------------------------------------------------------
// qmm_frame_if / qmm_drive_if
// Valid/ready channels for receiver frames in and motor drive values out.
// ----------------------------------------------------------------------------
interface qmm_frame_if import qmm_pkg::*; ();
	logic   valid;
	logic   ready;
	width_t throttle_width;
	width_t pitch_width;
	width_t roll_width;
	width_t yaw_width;

	modport source (output valid, throttle_width, pitch_width, roll_width, yaw_width,
		input ready);
	modport sink (input valid, throttle_width, pitch_width, roll_width, yaw_width,
		output ready);
endinterface

interface qmm_drive_if import qmm_pkg::*; ();
	logic   valid;
	logic   ready;
	power_t motor_one_power;
	power_t motor_two_power;
	power_t motor_three_power;
	power_t motor_four_power;
	thr_t   applied_throttle;

	modport source (output valid, motor_one_power, motor_two_power, motor_three_power,
		motor_four_power, applied_throttle, input ready);
	modport sink (input valid, motor_one_power, motor_two_power, motor_three_power,
		motor_four_power, applied_throttle, output ready);
endinterface

@@ hw/rtl/quad_motor_mixer.sv @@
// ----------------------------------------------------------------------------
// quad_motor_mixer
// Throttle slew/clamp and four-motor mix of one receiver frame per request.
// ----------------------------------------------------------------------------
// Takes one frame request per clock unless the drive side stalls, and offers
// its result from the result register. The throttle slew and clamp against the
// previous applied throttle are applied as the frame enters the input
// register. The three gain products and the mix are formed in one pass between
// the input register and the result register, which holds the motor power
// store. While a result waits on the drive side, one more frame is taken into
// the input register and then the frame side stalls. Offsets are written over
// the APB port at byte address 4*i and must only change while the block is idle.
module quad_motor_mixer import qmm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	qmm_frame_if.sink           frame,
	qmm_drive_if.source         drive
);

	offset_t offset_q [NUM_MOTORS];
	thr_t    prev_thr_q;

	logic    v_s1, v_q;
	logic    en_s1, en_q;
	thr_t    thr_s1, thr_q;
	width_t  pitch_s1, roll_s1, yaw_s1;
	prod_t   px, ry, yz;
	power_t  power_q [NUM_MOTORS];

	logic signed [SLEW_W-1:0] thr_in, prev_ext, thr_slew;
	thr_t    thr_new;

	sum_t    mix_sum [NUM_MOTORS];
	sum_t    total   [NUM_MOTORS];
	demand_t demand  [NUM_MOTORS];
	logic    cfg_wr;
	reg_idx_t cfg_idx;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign prdata  = DATA_W'(signed'(offset_q[cfg_idx]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MOTORS; i++) offset_q[i] <= '0;
		end else if (cfg_wr) begin
			offset_q[cfg_idx] <= offset_t'(pwdata[OFFSET_W-1:0]);
		end
	end

	// stage enables: each stage moves when the next one is empty or moving
	assign en_q        = !v_q || drive.ready;
	assign en_s1       = !v_s1 || en_q;
	assign frame.ready = en_s1;

	// throttle slew and clamp against the previous applied throttle
	always_comb begin
		thr_in   = SLEW_W'(signed'({1'b0, frame.throttle_width}));
		prev_ext = SLEW_W'(signed'({1'b0, prev_thr_q}));
		if (prev_ext - thr_in > SLEW_LIMIT) begin
			thr_slew = thr_in - SLEW_STEP;
		end else if (thr_in - prev_ext > SLEW_LIMIT) begin
			thr_slew = thr_in + SLEW_STEP;
		end else begin
			thr_slew = thr_in;
		end
		if (thr_slew > SLEW_W'(signed'({1'b0, THR_MAX}))) begin
			thr_new = THR_MAX;
		end else if (thr_slew < SLEW_W'(signed'({1'b0, THR_MIN}))) begin
			thr_new = THR_MIN;
		end else begin
			thr_new = thr_slew[THR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_thr_q <= THR_RESET;
			v_s1       <= 1'b0;
			v_q        <= 1'b0;
		end else begin
			if (frame.valid && en_s1) prev_thr_q <= thr_new;
			if (en_s1) v_s1 <= frame.valid;
			if (en_q)  v_q  <= v_s1;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (frame.valid && en_s1) begin
			thr_s1   <= thr_new;
			pitch_s1 <= frame.pitch_width;
			roll_s1  <= frame.roll_width;
			yaw_s1   <= frame.yaw_width;
		end
	end

	// gain products
	assign px = PROD_W'(pitch_s1) * PROD_W'(MIX_GAIN);
	assign ry = PROD_W'(roll_s1) * PROD_W'(MIX_GAIN);
	assign yz = PROD_W'(yaw_s1) * PROD_W'(MIX_GAIN);

	// mix, truncate toward zero
	always_comb begin
		sum_t    p, r, y;
		logic signed [BASE_W-1:0] base;
		p = sum_t'({4'b0, px});
		r = sum_t'({4'b0, ry});
		y = sum_t'({4'b0, yz});
		mix_sum[0] = -p - y;
		mix_sum[1] =  r + y;
		mix_sum[2] =  p - y;
		mix_sum[3] = -r + y;
		for (int i = 0; i < NUM_MOTORS; i++) begin
			base = signed'({2'b00, thr_s1}) + BASE_W'(offset_q[i]);
			total[i] = sum_t'({DEM_W'(base), {FRAC_W{1'b0}}}) + mix_sum[i];
			demand[i] = total[i][SUM_W-1:FRAC_W];
			if (total[i][SUM_W-1] && (|total[i][FRAC_W-1:0])) begin
				demand[i] = demand[i] + DEM_W'(1);
			end
		end
	end

	// result register; a motor keeps its stored value when the demand is too high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MOTORS; i++) power_q[i] <= MOTOR_RESET;
		end else if (v_s1 && en_q) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				if (demand[i] < DEMAND_LIMIT) power_q[i] <= demand[i][POWER_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && en_q) thr_q <= thr_s1;
	end

	assign drive.valid             = v_q;
	assign drive.motor_one_power   = power_q[0];
	assign drive.motor_two_power   = power_q[1];
	assign drive.motor_three_power = power_q[2];
	assign drive.motor_four_power  = power_q[3];
	assign drive.applied_throttle  = thr_q;

endmodule

@@ hw/rtl/qmm_checker.sv @@
// ----------------------------------------------------------------------------
// qmm_checker
// Port-level checks of the quad motor mixer, bound to the top level.
// ----------------------------------------------------------------------------
module qmm_checker import qmm_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   drive_valid,
	input logic   drive_ready,
	input power_t motor_one_power,
	input power_t motor_two_power,
	input power_t motor_three_power,
	input power_t motor_four_power,
	input thr_t   applied_throttle
);

	// a waiting result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && !drive_ready |=> drive_valid)
		else $error("drive request dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && !drive_ready |=> $stable(applied_throttle) && $stable(motor_one_power))
		else $error("drive payload changed while stalled");

	// applied throttle always inside the clamp window
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> applied_throttle >= THR_MIN && applied_throttle <= THR_MAX)
		else $error("applied throttle out of range");

	// stored motor values never reach the demand limit
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> motor_one_power < 19'sd160 && motor_two_power < 19'sd160
			&& motor_three_power < 19'sd160 && motor_four_power < 19'sd160)
		else $error("motor power at or above limit");

endmodule

bind quad_motor_mixer qmm_checker u_qmm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.drive_valid       (drive.valid),
	.drive_ready       (drive.ready),
	.motor_one_power   (drive.motor_one_power),
	.motor_two_power   (drive.motor_two_power),
	.motor_three_power (drive.motor_three_power),
	.motor_four_power  (drive.motor_four_power),
	.applied_throttle  (drive.applied_throttle)
);

@@ dv/quad_motor_mixer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quad_motor_mixer_tb
// Drives receiver frames through the frame channel and checks every drive
// result against a predictor of the throttle slew/clamp and the motor mix,
// across several motor trim settings written over the APB port.
// ----------------------------------------------------------------------------
module quad_motor_mixer_tb;
	import qmm_pkg::*;

	localparam longint GAIN_Q16    = 208608;
	localparam longint Q16_ONE     = 65536;
	localparam int     THR_TOP     = 160;
	localparam int     THR_BOTTOM  = 100;
	localparam int     THR_START   = 120;
	localparam int     SLEW_BAND   = 10;
	localparam int     SLEW_KICK   = 5;
	localparam int     POWER_START = 100;
	localparam int     STALL_LIMIT = 2000;
	localparam int     NUM_PHASES  = 6;
	localparam int     PHASE_ITEMS = 300;

	typedef struct packed {
		width_t throttle;
		width_t pitch;
		width_t roll;
		width_t yaw;
	} frame_rec_t;

	typedef struct packed {
		power_t motor_one;
		power_t motor_two;
		power_t motor_three;
		power_t motor_four;
		thr_t   throttle;
	} drive_rec_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	qmm_frame_if fr ();
	qmm_drive_if dr ();

	quad_motor_mixer uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.frame   (fr),
		.drive   (dr)
	);

	// predictor state
	int         prev_thr;
	power_t     motor_store [NUM_MOTORS];
	offset_t    trim [NUM_MOTORS];
	drive_rec_t drive_expect_q [$];

	int  mismatches;
	int  frames_sent;
	int  drives_seen;
	int  trim_settings;
	int  idle_cycles;
	int  rx_hold_req;
	int  rx_stall;
	bit  rx_random;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
	endfunction

	task automatic check_value(input string what, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0d, got %0d", what, want, got);
		end
	endtask

	// slew/clamp the throttle, mix the four motors and update the stores
	function automatic drive_rec_t mix_frame(input frame_rec_t f);
		int         t;
		longint     px;
		longint     ry;
		longint     yz;
		longint     mix [NUM_MOTORS];
		longint     demand;
		drive_rec_t d;
		t  = int'(f.throttle);
		px = longint'(f.pitch) * GAIN_Q16;
		ry = longint'(f.roll) * GAIN_Q16;
		yz = longint'(f.yaw) * GAIN_Q16;
		if (prev_thr - t > SLEW_BAND)
			t -= SLEW_KICK;
		else if (t - prev_thr > SLEW_BAND)
			t += SLEW_KICK;
		if (t > THR_TOP)
			t = THR_TOP;
		if (t < THR_BOTTOM)
			t = THR_BOTTOM;
		prev_thr = t;
		mix[0] = -px - yz;
		mix[1] = ry + yz;
		mix[2] = px - yz;
		mix[3] = -ry + yz;
		for (int i = 0; i < NUM_MOTORS; i++) begin
			// signed division truncates toward zero
			demand = (longint'(t + int'(trim[i])) * Q16_ONE + mix[i]) / Q16_ONE;
			if (demand < THR_TOP)
				motor_store[i] = power_t'(demand);
		end
		d.motor_one   = motor_store[0];
		d.motor_two   = motor_store[1];
		d.motor_three = motor_store[2];
		d.motor_four  = motor_store[3];
		d.throttle    = thr_t'(t);
		return d;
	endfunction

	function automatic frame_rec_t mk_frame(input int t, input int p, input int r, input int y);
		frame_rec_t f;
		f.throttle = width_t'(t);
		f.pitch    = width_t'(p);
		f.roll     = width_t'(r);
		f.yaw      = width_t'(y);
		return f;
	endfunction

	function automatic frame_rec_t random_frame();
		frame_rec_t f;
		int         kind;
		int         t;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			// throttle around the last applied value, small rotation commands
			t = prev_thr + $urandom_range(0, 44) - 22;
			if (t < 0 || $urandom_range(0, 40) == 0)
				t = 0;
			f = mk_frame(t, $urandom_range(0, 24), $urandom_range(0, 24),
				$urandom_range(0, 24));
		end else if (kind < 9) begin
			f = mk_frame($urandom_range(0, 25000), $urandom_range(0, 25000),
				$urandom_range(0, 25000), $urandom_range(0, 25000));
		end else begin
			f = frame_rec_t'({$urandom, $urandom});
		end
		return f;
	endfunction

	task automatic send_frame(input frame_rec_t f, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			fr.valid = 1'b0;
			{fr.throttle_width, fr.pitch_width, fr.roll_width, fr.yaw_width} =
				frame_rec_t'({$urandom, $urandom});
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		fr.valid          = 1'b1;
		fr.throttle_width = f.throttle;
		fr.pitch_width    = f.pitch;
		fr.roll_width     = f.roll;
		fr.yaw_width      = f.yaw;
		@(posedge clk);
		while (!fr.ready) @(posedge clk);
		drive_expect_q.push_back(mix_frame(f));
		frames_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		fr.valid = 1'b0;
		while (drive_expect_q.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input offset_t val);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		// only the low byte counts, the rest is noise
		pwdata  = {24'($urandom), val};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		trim[idx] = val;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic apb_read_check(input reg_idx_t idx);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		check_value($sformatf("trim readback %s", idx.name()), trim[idx],
			offset_t'(prdata[OFFSET_W-1:0]));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_trims(input offset_t a, input offset_t b, input offset_t c,
		input offset_t d);
		wait_drained();
		apb_write(REG_OFFSET_ONE, a);
		apb_write(REG_OFFSET_TWO, b);
		apb_write(REG_OFFSET_THREE, c);
		apb_write(REG_OFFSET_FOUR, d);
		for (int i = 0; i < NUM_MOTORS; i++)
			apb_read_check(reg_idx_t'(i));
		trim_settings++;
	endtask

	// receiver: random stalls, plus long holds asked for by the tests
	initial begin
		dr.ready = 1'b0;
		rx_stall = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_req > 0) begin
				rx_stall    = rx_hold_req;
				rx_hold_req = 0;
			end else if (rx_stall == 0 && rx_random && $urandom_range(0, 5) == 0) begin
				rx_stall = pick_gap();
			end
			if (rx_stall > 0) begin
				dr.ready = 1'b0;
				rx_stall--;
			end else begin
				dr.ready = 1'b1;
			end
		end
	end

	// result checker
	initial begin
		drive_rec_t want;
		forever begin
			@(posedge clk);
			if (dr.valid && dr.ready) begin
				drives_seen++;
				if (drive_expect_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: drive result with no frame outstanding");
				end else begin
					want = drive_expect_q.pop_front();
					check_value("motor_one_power", want.motor_one, dr.motor_one_power);
					check_value("motor_two_power", want.motor_two, dr.motor_two_power);
					check_value("motor_three_power", want.motor_three,
						dr.motor_three_power);
					check_value("motor_four_power", want.motor_four, dr.motor_four_power);
					check_value("applied_throttle", want.throttle, dr.applied_throttle);
				end
			end
		end
	end

	// watchdog on cycles with no traffic at all
	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((fr.valid && fr.ready) || (dr.valid && dr.ready) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("quad_motor_mixer_tb NOT OK");
		$finish;
	end

	task automatic test_reset_state();
		for (int i = 0; i < NUM_MOTORS; i++)
			apb_read_check(reg_idx_t'(i));
		send_frame(mk_frame(THR_START, 0, 0, 0), 0);
	endtask

	task automatic test_throttle_slew();
		send_frame(mk_frame(130, 0, 0, 0), 0);     // rise of exactly the band
		send_frame(mk_frame(141, 0, 0, 0), 1);     // rise past the band
		send_frame(mk_frame(136, 0, 0, 0), 0);     // fall of exactly the band
		send_frame(mk_frame(125, 0, 0, 0), 2);     // fall past the band
		send_frame(mk_frame(0, 0, 0, 0), 0);       // receiver timeout
		send_frame(mk_frame(25000, 0, 0, 0), 0);   // clamp high, demand 160 holds
		send_frame(mk_frame(32767, 0, 0, 0), 0);
		send_frame(mk_frame(159, 0, 0, 0), 0);     // demand just under the limit
		send_frame(mk_frame(99, 0, 0, 0), 3);      // clamp low
	endtask

	task automatic test_mix_extremes();
		send_frame(mk_frame(130, 1, 1, 1), 0);     // fractional truncation both ways
		send_frame(mk_frame(130, 32767, 0, 0), 0);
		send_frame(mk_frame(130, 0, 32767, 0), 1);
		send_frame(mk_frame(130, 0, 0, 32767), 0);
		send_frame(mk_frame(130, 32767, 32767, 32767), 0);
		send_frame(mk_frame(130, 21845, 10922, 21845), 0);
		send_frame(mk_frame(130, 10922, 21845, 10922), 0);
		send_frame(mk_frame(130, 10, 0, 0), 0);    // one motor over the limit holds
	endtask

	task automatic test_trim_extremes();
		set_trims(offset_t'(127), offset_t'(127), offset_t'(127), offset_t'(127));
		send_frame(mk_frame(100, 0, 0, 0), 0);
		set_trims(offset_t'(-128), offset_t'(-128), offset_t'(-128), offset_t'(-128));
		send_frame(mk_frame(100, 0, 0, 0), 0);
		send_frame(mk_frame(160, 0, 0, 0), 0);
		set_trims(offset_t'(127), offset_t'(-128), offset_t'(-1), offset_t'(0));
		send_frame(mk_frame(140, 3, 5, 2), 0);
	endtask

	task automatic test_backpressure();
		wait_drained();
		rx_hold_req = 60;
		for (int i = 0; i < 16; i++)
			send_frame(random_frame(), 0);
		wait_drained();
	endtask

	task automatic test_random_mix();
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: set_trims(offset_t'($urandom), offset_t'($urandom), offset_t'($urandom),
					offset_t'($urandom));
				1: set_trims(offset_t'(127), offset_t'(127), offset_t'(127),
					offset_t'(127));
				2: set_trims(offset_t'(-128), offset_t'(-128), offset_t'(-128),
					offset_t'(-128));
				3: set_trims(offset_t'(-1), offset_t'(0), offset_t'(127), offset_t'(-128));
				default: set_trims(offset_t'($urandom_range(0, 32) - 16),
					offset_t'($urandom_range(0, 32) - 16),
					offset_t'($urandom_range(0, 32) - 16),
					offset_t'($urandom_range(0, 32) - 16));
			endcase
			// last phase runs with both sides always busy
			rx_random = (ph != NUM_PHASES - 1);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_frame(random_frame(),
					(rx_random && $urandom_range(0, 2) == 0) ? pick_gap() : 0);
		end
		rx_random = 1'b1;
	endtask

	initial begin
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		fr.valid    = 1'b0;
		fr.throttle_width = '0;
		fr.pitch_width    = '0;
		fr.roll_width     = '0;
		fr.yaw_width      = '0;
		rx_random   = 1'b1;
		rx_hold_req = 0;
		mismatches  = 0;
		frames_sent = 0;
		drives_seen = 0;
		trim_settings = 1;
		prev_thr    = THR_START;
		for (int i = 0; i < NUM_MOTORS; i++) begin
			motor_store[i] = power_t'(POWER_START);
			trim[i]        = '0;
		end
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_throttle_slew();
		test_mix_extremes();
		test_trim_extremes();
		test_backpressure();
		test_random_mix();

		wait_drained();
		repeat (10) @(posedge clk);
		$display("sent %0d frames under %0d trim settings, checked %0d drive results",
			frames_sent, trim_settings, drives_seen);
		$display("slew band edges, clamps, held motors and a long output stall included");
		if (mismatches == 0)
			$display("quad_motor_mixer_tb OK");
		else
			$display("quad_motor_mixer_tb NOT OK");
		$finish;
	end

endmodule
